// ===== rtl/tte_pkg.sv =====
// ============================================================================
// Tap tempo estimator package
// Shared types and fixed constants for the tap tempo estimator.
// ============================================================================
`default_nettype none

package tte_pkg;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_GAP,
        S_RDOLD,
        S_SPAN,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_CHECK,
        S_DIV,
        S_FIN
    } t_state;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_GAP_LIMIT    = 2'd0;
    localparam t_cfg_index CFG_MIN_INTERVAL = 2'd1;
    localparam t_cfg_index CFG_TICKS_PER_MIN = 2'd2;

    // Register widths and reset values.
    localparam int unsigned GAP_W  = 32;
    localparam int unsigned MIN_W  = 32;
    localparam int unsigned TPM_W  = 40;
    localparam int unsigned CFG_DATA_W = 40;
    localparam logic [GAP_W-1:0] GAP_LIMIT_RST    = 32'd2000000;
    localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = 32'd1000;
    localparam logic [TPM_W-1:0] TICKS_PER_MIN_RST = 40'd60000000;

    // Tempo is reported in hundredths of a beat per minute.
    localparam int unsigned SCALE_W = 7;
    localparam logic [SCALE_W-1:0] BPM_SCALE = 7'd100;

    // Quotient width and its saturation value.
    localparam int unsigned QUOT_BITS = 24;
    localparam int unsigned DIV_CNT_W = $clog2(QUOT_BITS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_BITS - 1);
    localparam logic [QUOT_BITS-1:0] BPM_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/tap_tempo_estimator_unit.sv =====
// ============================================================================
// Tap tempo estimator
// Turns a stream of timestamped taps into a tempo in hundredths of BPM.
// ============================================================================
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+--------------------------------
//  tap     | in        | i_tap_valid / o_tap_ready  | i_tap_time
//  result  | out       | o_res_valid / i_res_ready  | o_tempo_valid, o_bpm_hundredths,
//          |           |                            | o_taps_held
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// From acceptance, a tap item passes the gap test and goes straight to the result
// register when fewer than two taps are held; it skips the division when the span
// is too short or the tempo saturates, and runs the division otherwise. The
// restoring divider produces one quotient bit per cycle, 24 bits in all, on a
// single shared subtractor, after setup states for the gap test, the
// oldest-tap read, the span, three passes through the shared multiplier and
// the range check; a final state loads the result register. The tap channel
// is ready again in the cycle after the result is loaded.
// Reset is synchronous and active low; it restores the register defaults and
// empties the history. The history memory itself is not cleared.
// The result sits in an output register, so a new tap is accepted while the
// previous result still waits; the sequencer stalls in its last state only if
// that register is still occupied when the next result is ready.
// Configuration writes are always accepted and must happen while idle.
//
// Operation: a tap whose gap from the newest held tap exceeds the gap limit
// clears the history first. The tap is written into a ring of HISTORY_DEPTH
// timestamps and the fill count saturates at the depth. With n >= 2 taps held,
// span = newest - oldest (wrapping). When span exceeds min_interval * (n - 1),
// tempo = ticks_per_minute * 100 * (n - 1) / span, saturated to 24 bits.
`default_nettype none

module tap_tempo_estimator_unit #(
    parameter int unsigned HISTORY_DEPTH = 8,
    parameter int unsigned TIME_WIDTH    = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Tap channel.
    input  wire logic                                  i_tap_valid,
    output logic                                       o_tap_ready,
    input  wire logic [TIME_WIDTH-1:0]                 i_tap_time,
    // Result channel.
    output logic                                       o_res_valid,
    input  wire logic                                  i_res_ready,
    output logic                                       o_tempo_valid,
    output logic [tte_pkg::QUOT_BITS-1:0]              o_bpm_hundredths,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]         o_taps_held,
    // Configuration channel.
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tte_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire logic [tte_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    // Widths derived from the parameters.
    localparam int unsigned TW   = TIME_WIDTH;
    localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);      // fill count
    localparam int unsigned SLW  = $clog2(HISTORY_DEPTH);          // ring slot
    localparam int unsigned AW   = CW + 1;                         // slot arithmetic
    localparam int unsigned QB   = tte_pkg::QUOT_BITS;
    localparam int unsigned MAW  = tte_pkg::TPM_W + tte_pkg::SCALE_W;
    localparam int unsigned MBW  = (CW > tte_pkg::SCALE_W) ? CW : tte_pkg::SCALE_W;
    localparam int unsigned PW   = MAW + MBW;                      // product width
    localparam int unsigned NW   = MAW + CW;                       // dividend width
    localparam int unsigned THW  = tte_pkg::MIN_W + CW;            // threshold width
    localparam int unsigned GCW  = (TW > tte_pkg::GAP_W) ? TW : tte_pkg::GAP_W;
    localparam int unsigned SCW  = (TW > THW) ? TW : THW;
    localparam int unsigned SATW = (NW > TW + QB) ? NW : TW + QB;
    localparam int unsigned SUBW = TW + 2;
    localparam int unsigned DIV_CNT_W_L = tte_pkg::DIV_CNT_W;
    localparam logic [SLW-1:0] SLOT_LAST = SLW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0]  FILL_FULL = CW'(HISTORY_DEPTH);

    // Configuration registers.
    logic [tte_pkg::GAP_W-1:0] r_gap_limit;
    logic [tte_pkg::MIN_W-1:0] r_min_interval;
    logic [tte_pkg::TPM_W-1:0] r_ticks_per_min;

    // Sequencer and history state.
    tte_pkg::t_state r_state, n_state;
    logic [SLW-1:0]  r_wslot, n_wslot;
    logic [CW-1:0]   r_fill, n_fill;
    logic [TW-1:0]   r_hist [HISTORY_DEPTH];
    logic [TW-1:0]   r_rd_data;

    // Datapath registers.
    logic [TW-1:0]        r_now;
    logic [TW-1:0]        r_span;
    logic [NW-1:0]        r_num;
    logic [THW-1:0]       r_thr;
    logic [TW-1:0]        r_rem;
    logic [QB-1:0]        r_dlo;
    logic [QB-1:0]        r_quo;
    logic                 r_tv;
    logic [DIV_CNT_W_L-1:0] r_div_cnt;

    // Output register.
    logic                 r_o_valid;
    logic                 r_o_tempo;
    logic [QB-1:0]        r_o_bpm;
    logic [CW-1:0]        r_o_taps;

    // Control and shared units.
    logic                 mem_we, mem_re;
    logic [SLW-1:0]       mem_wr_addr, mem_rd_addr;
    logic [SUBW-2:0]      sub_a, sub_b;
    logic [SUBW-1:0]      sub_y;
    logic [MAW-1:0]       mul_a;
    logic [MBW-1:0]       mul_b;
    logic [PW-1:0]        mul_y;
    logic                 gap_clear;
    logic [SLW-1:0]       ws_base;
    logic [CW-1:0]        fill_base;
    logic [CW-1:0]        gaps;
    logic                 span_ok, span_sat;
    logic                 out_free;
    logic                 tap_acc;

    // Ring slot that lies k entries behind the write slot ws.
    function automatic logic [SLW-1:0] ring_back(input logic [SLW-1:0] ws,
                                                 input logic [CW-1:0]  k);
        logic [AW-1:0] sum;
        begin
            sum = AW'(ws) + AW'(HISTORY_DEPTH) - AW'(k);
            if (sum >= AW'(HISTORY_DEPTH)) begin
                sum = sum - AW'(HISTORY_DEPTH);
            end
            return SLW'(sum);
        end
    endfunction

    assign tap_acc     = i_tap_valid && o_tap_ready;
    assign out_free    = !r_o_valid || i_res_ready;
    assign gaps        = r_fill - CW'(1);

    // Shared subtractor and multiplier.
    assign sub_y = {1'b0, sub_a} - {1'b0, sub_b};
    assign mul_y = PW'(mul_a) * PW'(mul_b);

    // Gap test: only meaningful when taps are held.
    assign gap_clear = (r_fill != '0) &&
                       (GCW'(sub_y[TW-1:0]) > GCW'(r_gap_limit));
    assign ws_base   = gap_clear ? '0 : r_wslot;
    assign fill_base = gap_clear ? '0 : r_fill;

    assign span_ok  = (SCW'(r_span) > SCW'(r_thr)) && (r_span != '0);
    assign span_sat = SATW'(r_num) >= (SATW'(r_span) << QB);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tte_pkg::S_IDLE: begin
                if (tap_acc) begin
                    n_state = tte_pkg::S_GAP;
                end
            end
            tte_pkg::S_GAP: begin
                if (n_fill >= CW'(2)) begin
                    n_state = tte_pkg::S_RDOLD;
                end else begin
                    n_state = tte_pkg::S_FIN;
                end
            end
            tte_pkg::S_RDOLD: n_state = tte_pkg::S_SPAN;
            tte_pkg::S_SPAN:  n_state = tte_pkg::S_MUL1;
            tte_pkg::S_MUL1:  n_state = tte_pkg::S_MUL2;
            tte_pkg::S_MUL2:  n_state = tte_pkg::S_MUL3;
            tte_pkg::S_MUL3:  n_state = tte_pkg::S_CHECK;
            tte_pkg::S_CHECK: begin
                if (span_ok && !span_sat) begin
                    n_state = tte_pkg::S_DIV;
                end else begin
                    n_state = tte_pkg::S_FIN;
                end
            end
            tte_pkg::S_DIV: begin
                if (r_div_cnt == tte_pkg::DIV_LAST) begin
                    n_state = tte_pkg::S_FIN;
                end
            end
            tte_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = tte_pkg::S_IDLE;
                end
            end
            default: n_state = tte_pkg::S_IDLE;
        endcase
    end

    // Control outputs: memory access and shared unit operands.
    always_comb begin
        o_tap_ready = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wr_addr = ws_base;
        mem_rd_addr = ring_back(r_wslot, CW'(1));
        sub_a       = '0;
        sub_b       = '0;
        mul_a       = '0;
        mul_b       = '0;
        n_wslot     = r_wslot;
        n_fill      = r_fill;
        unique case (r_state) inside
            tte_pkg::S_IDLE: begin
                o_tap_ready = 1'b1;
                mem_re      = tap_acc;
            end
            tte_pkg::S_GAP, tte_pkg::S_SPAN: begin
                sub_a = {1'b0, r_now};
                sub_b = {1'b0, r_rd_data};
                if (r_state == tte_pkg::S_GAP) begin
                    mem_we  = 1'b1;
                    n_wslot = (ws_base == SLOT_LAST) ? '0 : ws_base + SLW'(1);
                    n_fill  = (fill_base == FILL_FULL) ? fill_base : fill_base + CW'(1);
                end
            end
            tte_pkg::S_RDOLD: begin
                mem_re      = 1'b1;
                mem_rd_addr = ring_back(r_wslot, r_fill);
            end
            tte_pkg::S_MUL1: begin
                mul_a = MAW'(r_ticks_per_min);
                mul_b = MBW'(tte_pkg::BPM_SCALE);
            end
            tte_pkg::S_MUL2: begin
                mul_a = MAW'(r_num);
                mul_b = MBW'(gaps);
            end
            tte_pkg::S_MUL3: begin
                mul_a = MAW'(r_min_interval);
                mul_b = MBW'(gaps);
            end
            tte_pkg::S_DIV: begin
                sub_a = {r_rem, r_dlo[QB-1]};
                sub_b = {1'b0, r_span};
            end
            default: begin
            end
        endcase
    end

    // History memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_wr_addr] <= r_now;
        end
        if (mem_re) begin
            r_rd_data <= r_hist[mem_rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tte_pkg::S_IDLE;
            r_wslot         <= '0;
            r_fill          <= '0;
            r_o_valid       <= 1'b0;
            r_gap_limit     <= tte_pkg::GAP_LIMIT_RST;
            r_min_interval  <= tte_pkg::MIN_INTERVAL_RST;
            r_ticks_per_min <= tte_pkg::TICKS_PER_MIN_RST;
        end else begin
            r_state <= n_state;
            r_wslot <= n_wslot;
            r_fill  <= n_fill;
            if (r_state == tte_pkg::S_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tte_pkg::CFG_GAP_LIMIT:
                        r_gap_limit <= i_cfg_data[tte_pkg::GAP_W-1:0];
                    tte_pkg::CFG_MIN_INTERVAL:
                        r_min_interval <= i_cfg_data[tte_pkg::MIN_W-1:0];
                    tte_pkg::CFG_TICKS_PER_MIN:
                        r_ticks_per_min <= i_cfg_data[tte_pkg::TPM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state) inside
            tte_pkg::S_IDLE: begin
                if (tap_acc) begin
                    r_now <= i_tap_time;
                end
            end
            tte_pkg::S_GAP: begin
                r_tv  <= 1'b0;
                r_quo <= '0;
            end
            tte_pkg::S_SPAN: begin
                r_span <= sub_y[TW-1:0];
            end
            tte_pkg::S_MUL1, tte_pkg::S_MUL2: begin
                r_num <= NW'(mul_y);
            end
            tte_pkg::S_MUL3: begin
                r_thr <= THW'(mul_y);
            end
            tte_pkg::S_CHECK: begin
                r_rem     <= TW'(r_num >> QB);
                r_dlo     <= r_num[QB-1:0];
                r_div_cnt <= '0;
                r_tv      <= span_ok;
                if (!span_ok) begin
                    r_quo <= '0;
                end else begin
                    r_quo <= tte_pkg::BPM_MAX;
                end
            end
            tte_pkg::S_DIV: begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W_L'(1);
                r_dlo     <= r_dlo << 1;
                r_quo     <= {r_quo[QB-2:0], ~sub_y[SUBW-1]};
                if (!sub_y[SUBW-1]) begin
                    r_rem <= sub_y[TW-1:0];
                end else begin
                    r_rem <= sub_a[TW-1:0];
                end
            end
            tte_pkg::S_FIN: begin
                if (out_free) begin
                    r_o_tempo <= r_tv;
                    r_o_bpm   <= r_quo;
                    r_o_taps  <= r_fill;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid      = r_o_valid;
    assign o_tempo_valid    = r_o_tempo;
    assign o_bpm_hundredths = r_o_bpm;
    assign o_taps_held      = r_o_taps;
    assign o_cfg_ready      = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/tte_checker.sv =====
// ============================================================================
// Tap tempo estimator checker
// Port-level assertions, bound to the top level.
// ============================================================================
`default_nettype none

module tte_checker #(
    parameter int unsigned HISTORY_DEPTH = 8,
    parameter int unsigned TIME_WIDTH    = 32
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_tap_valid,
    input wire logic                              o_tap_ready,
    input wire logic                              o_res_valid,
    input wire logic                              i_res_ready,
    input wire logic                              o_tempo_valid,
    input wire logic [tte_pkg::QUOT_BITS-1:0]     o_bpm_hundredths,
    input wire logic [$clog2(HISTORY_DEPTH+1)-1:0] o_taps_held
);

    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

    // A tempo of zero is reported whenever no tempo was computed.
    a_bpm_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_tempo_valid |-> o_bpm_hundredths == '0)
        else $error("bpm nonzero without a valid tempo");

    // The history always holds between one tap and its full depth.
    a_taps_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_taps_held != '0) && (o_taps_held <= CW'(HISTORY_DEPTH)))
        else $error("taps held out of range");

    // A single tap can never yield a tempo.
    a_single_tap_no_tempo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_taps_held == CW'(1)) |-> !o_tempo_valid)
        else $error("tempo reported from a single tap");

    // The block works on one tap at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tap_valid && o_tap_ready |=> !o_tap_ready)
        else $error("tap accepted on consecutive cycles");

    // A stalled result holds.
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_bpm_hundredths))
        else $error("stalled result changed");

endmodule

bind tap_tempo_estimator_unit tte_checker #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH)
) u_tte_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_tap_valid      (i_tap_valid),
    .o_tap_ready      (o_tap_ready),
    .o_res_valid      (o_res_valid),
    .i_res_ready      (i_res_ready),
    .o_tempo_valid    (o_tempo_valid),
    .o_bpm_hundredths (o_bpm_hundredths),
    .o_taps_held      (o_taps_held)
);

`default_nettype wire
